FILE: src/psc_pkg.sv
// Shared constants, widths and types of the polyline stroke coverage block.
package psc_pkg;

  localparam int SEGMENT_SLOTS   = 4;
  localparam int MAX_SIDE        = 1024;
  localparam int COORD_FRAC_BITS = 4;

  localparam int PIX_W     = 10;
  localparam int CW        = 16;
  localparam int SEG_W     = 4 * CW;
  localparam int HS_W      = 12;
  localparam int NSEG_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = SEG_W;
  localparam int CFG_SEGS  = 4;
  localparam int ALPHA_W   = 8;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NSEG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF = 3'd5;

  localparam int FINE_BITS = COORD_FRAC_BITS + 8;
  localparam int PXW   = PIX_W + COORD_FRAC_BITS;
  localparam int RXW   = ((PXW + 1 > CW) ? PXW + 1 : CW) + 1;
  localparam int DXW   = CW + 1;
  localparam int PRODW = RXW + DXW;
  localparam int DOTW  = PRODW + 1;
  localparam int LENW  = 2 * DXW;
  localparam int TFRAC = 16;
  localparam int TW    = TFRAC + 1;
  localparam int MW    = TW + 1 + DXW;
  localparam int VW    = ((RXW + TFRAC > MW) ? RXW + TFRAC : MW) + 2;
  localparam int EW    = VW - 8;
  localparam int D2W   = 2 * EW;
  localparam int QW    = EW;
  localparam int RW    = HS_W + 1 + 8;
  localparam int R2W   = 2 * RW;

  // Cycles one item spends in a cell.
  localparam int CELL_LAT = TFRAC + 10;

  typedef struct packed {
    logic [PXW-1:0] px;
    logic [PXW-1:0] py;
    logic [D2W-1:0] best;
    logic           any;
    logic           kill;
  } tok_t;

endpackage

FILE: src/psc_cell.sv
// One segment cell: distance from the pixel centre to its segment, min merge.
module psc_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       active,
  input  logic [psc_pkg::SEG_W-1:0]  seg,
  input  logic                       in_valid,
  input  psc_pkg::tok_t              in_tok,
  output logic                       out_valid,
  output psc_pkg::tok_t              out_tok
);

  localparam int CW    = psc_pkg::CW;
  localparam int RXW   = psc_pkg::RXW;
  localparam int DXW   = psc_pkg::DXW;
  localparam int PRODW = psc_pkg::PRODW;
  localparam int DOTW  = psc_pkg::DOTW;
  localparam int LENW  = psc_pkg::LENW;
  localparam int TFRAC = psc_pkg::TFRAC;
  localparam int TW    = psc_pkg::TW;
  localparam int MW    = psc_pkg::MW;
  localparam int VW    = psc_pkg::VW;
  localparam int EW    = psc_pkg::EW;
  localparam int D2W   = psc_pkg::D2W;

  // Segment geometry; the user must keep it static while items are in flight, as the cell does no check.
  logic signed [CW-1:0]  ax_r, ay_r;
  logic signed [DXW-1:0] dx_r, dy_r;
  logic [LENW-1:0]       dxx_r, dyy_r, len2_r;

  always_ff @(posedge clk) begin
    ax_r   <= $signed(seg[CW-1:0]);
    ay_r   <= $signed(seg[2*CW-1:CW]);
    dx_r   <= DXW'($signed(seg[3*CW-1:2*CW])) - DXW'($signed(seg[CW-1:0]));
    dy_r   <= DXW'($signed(seg[4*CW-1:3*CW])) - DXW'($signed(seg[2*CW-1:CW]));
    dxx_r  <= dx_r * dx_r;
    dyy_r  <= dy_r * dy_r;
    len2_r <= dxx_r + dyy_r;
  end

  logic                    v1_r, v2_r, v3_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r;
  psc_pkg::tok_t           tok1_r, tok2_r, tok3_r, tok5_r, tok6_r, tok7_r, tok8_r;
  psc_pkg::tok_t           tok9_r, tok10_r;
  logic signed [RXW-1:0]   rx1_r, ry1_r, rx2_r, ry2_r, rx3_r, ry3_r;
  logic signed [RXW-1:0]   rx5_r, ry5_r, rx6_r, ry6_r;
  logic signed [PRODW-1:0] prx2_r, pry2_r;
  logic signed [DOTW-1:0]  dot3_r;
  logic [TW-1:0]           t5_r;
  logic signed [MW-1:0]    mx6_r, my6_r;
  logic signed [EW-1:0]    ex7_r, ey7_r;
  logic [D2W-1:0]          sx8_r, sy8_r, d9_r;

  // Divider stages: index 0 holds the classified item, 1..TFRAC one quotient bit each.
  logic                    dv_r   [0:TFRAC];
  psc_pkg::tok_t           dtok_r [0:TFRAC];
  logic signed [RXW-1:0]   drx_r  [0:TFRAC];
  logic signed [RXW-1:0]   dry_r  [0:TFRAC];
  logic [LENW-1:0]         drem_r [0:TFRAC];
  logic [TFRAC-1:0]        dq_r   [0:TFRAC];
  logic                    dzero_r[0:TFRAC];
  logic                    dfull_r[0:TFRAC];

  logic                    zero_c, full_c;
  logic signed [VW-1:0]    vx_c, vy_c;
  logic signed [D2W-1:0]   exw_c, eyw_c;
  logic                    take_c;
  psc_pkg::tok_t           merge_c;

  assign zero_c = (len2_r == '0) || (dot3_r <= 0);
  assign full_c = dot3_r >= $signed(DOTW'(len2_r));

  assign vx_c  = (VW'(rx6_r) <<< TFRAC) - VW'(mx6_r) + VW'(128);
  assign vy_c  = (VW'(ry6_r) <<< TFRAC) - VW'(my6_r) + VW'(128);
  assign exw_c = D2W'(ex7_r);
  assign eyw_c = D2W'(ey7_r);
  assign take_c = active && (!tok9_r.any || (d9_r < tok9_r.best));

  // keep the smaller distance
  always_comb begin
    merge_c      = tok9_r;
    merge_c.best = take_c ? d9_r : tok9_r.best;
    merge_c.any  = tok9_r.any | active;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; dv_r[0] <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      v9_r <= 1'b0; v10_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; dv_r[0] <= v3_r;
      v5_r <= dv_r[TFRAC]; v6_r <= v5_r; v7_r <= v6_r; v8_r <= v7_r;
      v9_r <= v8_r; v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // offset of the pixel centre from the start point
      tok1_r <= in_tok;
      rx1_r  <= RXW'($signed({1'b0, in_tok.px})) - RXW'(ax_r);
      ry1_r  <= RXW'($signed({1'b0, in_tok.py})) - RXW'(ay_r);
      // projection products and dot product
      tok2_r <= tok1_r; rx2_r <= rx1_r; ry2_r <= ry1_r;
      prx2_r <= rx1_r * dx_r;
      pry2_r <= ry1_r * dy_r;
      tok3_r <= tok2_r; rx3_r <= rx2_r; ry3_r <= ry2_r;
      dot3_r <= DOTW'(prx2_r) + DOTW'(pry2_r);
      // classify t and seed the divider
      dtok_r[0]  <= tok3_r; drx_r[0] <= rx3_r; dry_r[0] <= ry3_r;
      dzero_r[0] <= zero_c;
      dfull_r[0] <= full_c;
      drem_r[0]  <= dot3_r[LENW-1:0];
      dq_r[0]    <= '0;
      // final t
      tok5_r <= dtok_r[TFRAC]; rx5_r <= drx_r[TFRAC]; ry5_r <= dry_r[TFRAC];
      if (dzero_r[TFRAC]) begin
        t5_r <= '0;
      end else if (dfull_r[TFRAC]) begin
        t5_r <= TW'(1) << TFRAC;
      end else begin
        t5_r <= {1'b0, dq_r[TFRAC]};
      end
      tok6_r <= tok5_r; rx6_r <= rx5_r; ry6_r <= ry5_r;
      mx6_r  <= $signed({1'b0, t5_r}) * dx_r;
      my6_r  <= $signed({1'b0, t5_r}) * dy_r;
      // round the offset to the fine grid
      tok7_r <= tok6_r;
      ex7_r  <= vx_c[VW-1:8];
      ey7_r  <= vy_c[VW-1:8];
      tok8_r <= tok7_r;
      sx8_r  <= exw_c * exw_c;
      sy8_r  <= eyw_c * eyw_c;
      tok9_r <= tok8_r;
      d9_r   <= sx8_r + sy8_r;
      tok10_r <= merge_c;
    end
  end

  for (genvar j = 1; j <= TFRAC; j++) begin : g_div
    logic [LENW:0] rem2;
    logic          ge;

    assign rem2 = {drem_r[j-1], 1'b0};
    assign ge   = rem2 >= {1'b0, len2_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (en) begin
        dv_r[j] <= dv_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dtok_r[j]  <= dtok_r[j-1];
        drx_r[j]   <= drx_r[j-1];
        dry_r[j]   <= dry_r[j-1];
        dzero_r[j] <= dzero_r[j-1];
        dfull_r[j] <= dfull_r[j-1];
        drem_r[j]  <= ge ? LENW'(rem2 - {1'b0, len2_r}) : LENW'(rem2);
        dq_r[j]    <= {dq_r[j-1][TFRAC-2:0], ge};
      end
    end
  end

  assign out_valid = v10_r;
  assign out_tok   = tok10_r;

endmodule

FILE: src/psc_isqrt.sv
// Pipelined integer square root of the least distance, plus the reach test.
module psc_isqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  psc_pkg::tok_t             in_tok,
  input  logic [psc_pkg::R2W-1:0]   r2,
  output logic                      out_valid,
  output logic                      out_cov,
  output logic [psc_pkg::QW-1:0]    out_root
);

  localparam int QW  = psc_pkg::QW;
  localparam int D2W = psc_pkg::D2W;

  logic            sv_r   [0:QW];
  logic            scov_r [0:QW];
  logic [D2W-1:0]  ss_r   [0:QW];
  logic [QW-1:0]   sroot_r[0:QW];
  logic [QW+1:0]   srem_r [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      scov_r[0]  <= in_tok.any && !in_tok.kill && (in_tok.best <= D2W'(r2));
      ss_r[0]    <= in_tok.best;
      sroot_r[0] <= '0;
      srem_r[0]  <= '0;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_root
    logic [QW+3:0] cur;
    logic [QW+3:0] trial;
    logic          ge;

    assign cur   = {srem_r[j-1], ss_r[j-1][D2W-1 -: 2]};
    assign trial = {2'b00, sroot_r[j-1], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j] <= 1'b0;
      end else if (en) begin
        sv_r[j] <= sv_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        scov_r[j]  <= scov_r[j-1];
        ss_r[j]    <= ss_r[j-1] << 2;
        sroot_r[j] <= {sroot_r[j-1][QW-2:0], ge};
        srem_r[j]  <= ge ? (QW+2)'(cur - trial) : (QW+2)'(cur);
      end
    end
  end

  assign out_valid = sv_r[QW];
  assign out_cov   = scov_r[QW];
  assign out_root  = sroot_r[QW];

endmodule

FILE: src/polyline_stroke_coverage.sv
// Top level: stroke coverage alpha of one pixel against a polyline of segments.
//
//  channel | dir | fields (low bit first)             | accepted when
//  in_     | in  | tdata: pixel_x[9:0] pixel_y[19:10] | in_tvalid && in_tready
//  out_    | out | tdata: alpha[7:0] covered[8]       | out_tvalid && out_tready
//  cfg_    | in  | wen, index, wdata (64 bits)        | cfg_wen
//
// One pixel enters per cycle while the skid register is empty; each pixel is
// independent of the one before. Each segment cell passes most of its stages
// through a restoring divider that yields one bit of the projection parameter
// per stage, and the square root of the least distance takes one root bit per
// stage.
// Reset (rst_n, synchronous) clears all pipeline valid bits and restores the
// register defaults. When the output is stalled, the one result that is in
// motion lands in a skid register and the whole pipeline holds after that.
module polyline_stroke_coverage #(
  parameter int SEGMENT_SLOTS = psc_pkg::SEGMENT_SLOTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // pixel_x [9:0], pixel_y [19:10], zero [23:20]
  input  logic [psc_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // alpha [7:0], covered [8], zero [15:9]
  output logic [psc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wen,
  input  logic [psc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psc_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int F       = psc_pkg::COORD_FRAC_BITS;
  localparam int PIX_W   = psc_pkg::PIX_W;
  localparam int PXW     = psc_pkg::PXW;
  localparam int RW      = psc_pkg::RW;
  localparam int R2W     = psc_pkg::R2W;
  localparam int QW      = psc_pkg::QW;
  localparam int ALPHA_W = psc_pkg::ALPHA_W;
  localparam int HS_W    = psc_pkg::HS_W;
  localparam int NSEG_W  = psc_pkg::NSEG_W;
  localparam int SEG_W   = psc_pkg::SEG_W;
  localparam int CFG_IDX_W = psc_pkg::CFG_IDX_W;
  localparam int RES_W   = ALPHA_W + 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [SEG_W-1:0]  seg_r [0:SEGMENT_SLOTS-1];
  logic [NSEG_W-1:0] nseg_r;
  logic [HS_W-1:0]   half_r;
  logic [RW-1:0]     reach_r;
  logic [R2W-1:0]    reach2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nseg_r <= NSEG_W'(4);
      half_r <= HS_W'(16);
    end else if (cfg_wen) begin
      if (cfg_index == psc_pkg::CFG_IDX_NSEG) begin
        nseg_r <= cfg_wdata[NSEG_W-1:0];
      end
      if (cfg_index == psc_pkg::CFG_IDX_HALF) begin
        half_r <= cfg_wdata[HS_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < SEGMENT_SLOTS; k++) begin : g_seg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        seg_r[k] <= '0;
      end else if (cfg_wen && (k < psc_pkg::CFG_SEGS) &&
                   (cfg_index == CFG_IDX_W'(k))) begin
        seg_r[k] <= cfg_wdata;
      end
    end
  end

  // Reach (half stroke plus one pixel) on the fine grid, and its square.
  always_ff @(posedge clk) begin
    reach_r  <= (RW'(half_r) + RW'(1 << F)) << 8;
    reach2_r <= reach_r * reach_r;
  end

  // ---------------------------------------------------------------------
  // Pipeline advance and entry
  // ---------------------------------------------------------------------
  logic skid_v_r, out_v_r;
  logic en;

  assign en        = !skid_v_r;
  assign in_tready = en;

  logic [PIX_W-1:0] pix_x, pix_y;
  psc_pkg::tok_t    entry_tok;

  assign pix_x = in_tdata[PIX_W-1:0];
  assign pix_y = in_tdata[2*PIX_W-1:PIX_W];

  // Pixel centre in Q.F; flag pixels outside the mask.
  always_comb begin
    entry_tok      = '0;
    entry_tok.px   = PXW'({pix_x, {F{1'b0}}}) + PXW'(1 << (F - 1));
    entry_tok.py   = PXW'({pix_y, {F{1'b0}}}) + PXW'(1 << (F - 1));
    entry_tok.kill = (32'(pix_x) >= psc_pkg::MAX_SIDE) ||
                     (32'(pix_y) >= psc_pkg::MAX_SIDE);
  end

  // ---------------------------------------------------------------------
  // Row of segment cells: each hands the running minimum to the next
  // ---------------------------------------------------------------------
  logic          chain_v   [0:SEGMENT_SLOTS];
  psc_pkg::tok_t chain_tok [0:SEGMENT_SLOTS];

  assign chain_v[0]   = in_tvalid;
  assign chain_tok[0] = entry_tok;

  for (genvar k = 0; k < SEGMENT_SLOTS; k++) begin : g_cell
    logic active;

    // Slots at or above the count are skipped; a count above the slots covers all.
    assign active = int'(nseg_r) > k;

    psc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .active    (active),
      .seg       (seg_r[k]),
      .in_valid  (chain_v[k]),
      .in_tok    (chain_tok[k]),
      .out_valid (chain_v[k+1]),
      .out_tok   (chain_tok[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Square root of the least distance and the reach test
  // ---------------------------------------------------------------------
  logic          fin_v, fin_cov;
  logic [QW-1:0] fin_root;

  psc_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (chain_v[SEGMENT_SLOTS]),
    .in_tok    (chain_tok[SEGMENT_SLOTS]),
    .r2        (reach2_r),
    .out_valid (fin_v),
    .out_cov   (fin_cov),
    .out_root  (fin_root)
  );

  // Alpha = (reach - root) * 255 on the fine grid, saturated. When covered the
  // root never exceeds the reach, so the difference fits the reach width.
  logic [RW-1:0]    diff_c;
  logic [RW+7:0]    scaled_c;
  logic [RW+7:0]    shr_c;
  logic [RES_W-1:0] fin_res;

  always_comb begin
    diff_c   = reach_r - RW'(fin_root);
    scaled_c = {diff_c, 8'b0} - (RW+8)'(diff_c);
    shr_c    = scaled_c >> psc_pkg::FINE_BITS;
    fin_res  = '0;
    if (fin_cov) begin
      fin_res[ALPHA_W] = 1'b1;
      fin_res[ALPHA_W-1:0] = (shr_c > (RW+8)'(255)) ? ALPHA_W'(255) : shr_c[ALPHA_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------
  logic [RES_W-1:0] out_d_r, skid_d_r;
  logic             out_v_nxt, skid_v_nxt, load_out, load_skid;
  logic [RES_W-1:0] out_d_nxt;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_d_nxt  = out_d_r;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    if (out_v_r && !out_tready) begin
      // hold the output; park a result in motion
      if (fin_v && en) begin
        skid_v_nxt = 1'b1;
        load_skid  = 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      load_out   = 1'b1;
      skid_v_nxt = 1'b0;
    end else begin
      out_v_nxt = fin_v;
      out_d_nxt = fin_res;
      load_out  = fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_d_r <= out_d_nxt;
    end
    if (load_skid) begin
      skid_d_r <= fin_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = psc_pkg::OUT_TDATA_W'(out_d_r);

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  a_skid_from_stall : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid register loaded without an output stall");

  a_uncovered_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_d_r[ALPHA_W]) |-> (out_d_r[ALPHA_W-1:0] == '0))
    else $error("nonzero alpha on an uncovered pixel");

  a_drain_skid : assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && out_tready) |=> (out_v_r && !skid_v_r))
    else $error("skid register not drained after output taken");

endmodule

FILE: sim/polyline_stroke_coverage_tb.sv
// Self-checking testbench of the polyline stroke coverage block.
module polyline_stroke_coverage_tb;

  localparam int SEGMENT_SLOTS   = psc_pkg::SEGMENT_SLOTS;
  localparam int MAX_SIDE        = psc_pkg::MAX_SIDE;
  localparam int COORD_FRAC_BITS = psc_pkg::COORD_FRAC_BITS;
  localparam int FINE_BITS       = psc_pkg::FINE_BITS;
  localparam int PIX_W           = psc_pkg::PIX_W;
  localparam int CW              = psc_pkg::CW;
  localparam int SEG_W           = psc_pkg::SEG_W;
  localparam int HS_W            = psc_pkg::HS_W;
  localparam int NSEG_W          = psc_pkg::NSEG_W;
  localparam int CFG_IDX_W       = psc_pkg::CFG_IDX_W;
  localparam int CFG_W           = psc_pkg::CFG_W;
  localparam int CFG_SEGS        = psc_pkg::CFG_SEGS;
  localparam int ALPHA_W         = psc_pkg::ALPHA_W;
  localparam int IN_TDATA_W      = psc_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W     = psc_pkg::OUT_TDATA_W;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG0 = psc_pkg::CFG_IDX_SEG0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG1 = psc_pkg::CFG_IDX_SEG1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG2 = psc_pkg::CFG_IDX_SEG2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SEG3 = psc_pkg::CFG_IDX_SEG3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NSEG = psc_pkg::CFG_IDX_NSEG;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HALF = psc_pkg::CFG_IDX_HALF;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic               covered;
  } coverage_t;

  // Shadow copy of the configuration registers.
  logic [SEG_W-1:0]  shadow_seg [SEGMENT_SLOTS];
  logic [NSEG_W-1:0] shadow_nseg;
  logic [HS_W-1:0]   shadow_half;

  coverage_t pending_cov[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  sink_idle_en = 1'b0;
  int  sink_hold_cycles = 0;
  bit  src_idle_en = 1'b0;

  always #5 clk = ~clk;

  polyline_stroke_coverage u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic longint signed coord16(logic [SEG_W-1:0] w, int idx);
    logic signed [CW-1:0] v;
    v = w[idx*CW +: CW];
    return longint'(v);
  endfunction

  // Floor division by 256, rounding toward minus infinity.
  function automatic longint signed floor256(longint signed v);
    return v >>> 8;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned seg_dist_sq(logic [SEG_W-1:0] w,
                                                   longint signed px, longint signed py);
    longint signed ax, ay, dx, dy, rx, ry, len2, dot, t, ex, ey;
    ax = coord16(w, 0);
    ay = coord16(w, 1);
    dx = coord16(w, 2) - ax;
    dy = coord16(w, 3) - ay;
    rx = px - ax;
    ry = py - ay;
    len2 = dx * dx + dy * dy;
    dot = rx * dx + ry * dy;
    if (len2 == 0 || dot <= 0) t = 0;
    else if (dot >= len2) t = 65536;
    else t = (dot * 65536) / len2;
    ex = floor256(rx * 65536 - t * dx + 128);
    ey = floor256(ry * 65536 - t * dy + 128);
    return longint'(ex * ex) + longint'(ey * ey);
  endfunction

  function automatic coverage_t predict_coverage(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    coverage_t res;
    int n;
    longint signed px, py;
    longint unsigned best, d2, r, q, a;
    res = '0;
    n = int'(shadow_nseg);
    if (x >= MAX_SIDE || y >= MAX_SIDE || n == 0) return res;
    if (n > SEGMENT_SLOTS) n = SEGMENT_SLOTS;
    px = (longint'(x) << COORD_FRAC_BITS) + (1 << (COORD_FRAC_BITS - 1));
    py = (longint'(y) << COORD_FRAC_BITS) + (1 << (COORD_FRAC_BITS - 1));
    best = 0;
    for (int i = 0; i < n; i++) begin
      d2 = seg_dist_sq(shadow_seg[i], px, py);
      if (i == 0 || d2 < best) best = d2;
    end
    r = (longint'(shadow_half) + (1 << COORD_FRAC_BITS)) << 8;
    if (best <= r * r) begin
      q = int_sqrt(best);
      a = ((r - q) * 255) >> FINE_BITS;
      if (a > 255) a = 255;
      res.alpha = a[ALPHA_W-1:0];
      res.covered = 1'b1;
    end
    return res;
  endfunction

  // Write one register; mirror it in the shadow copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_tvalid <= 1'b0;
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx < CFG_SEGS) shadow_seg[idx] = val;
    else if (idx == CFG_IDX_NSEG) shadow_nseg = val[NSEG_W-1:0];
    else if (idx == CFG_IDX_HALF) shadow_half = val[HS_W-1:0];
  endtask

  // Send one pixel; the expectation is queued at acceptance.
  task automatic send_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    while (src_idle_en && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_cov = {pending_cov, predict_coverage(x, y)};
  endtask

  // Wait for every result, then let the pipeline settle before reconfiguring.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_cov.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sink side: random idling, plus a long hold-off on request.
  always @(posedge clk) begin
    if (sink_hold_cycles > 0) begin
      out_tready <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles - 1;
    end else begin
      out_tready <= !(sink_idle_en && $urandom_range(99) < 23);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    coverage_t got, exp_cov;
    if (rst_n && out_tvalid && out_tready) begin
      got.alpha = out_tdata[ALPHA_W-1:0];
      got.covered = out_tdata[ALPHA_W];
      if (pending_cov.size() == 0) begin
        $error("unexpected result alpha=%0d covered=%0d", got.alpha, got.covered);
        fail_count++;
      end else begin
        exp_cov = pending_cov.pop_front();
        if (got.alpha !== exp_cov.alpha) begin
          $error("alpha expected %0d actual %0d", exp_cov.alpha, got.alpha);
          fail_count++;
        end
        if (got.covered !== exp_cov.covered) begin
          $error("covered expected %0d actual %0d", exp_cov.covered, got.covered);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [15:0] rand_coord();
    logic [15:0] v;
    v = 16'($urandom_range(16 * 1023));
    if ($urandom_range(9) == 0) v = 16'($urandom);
    return v;
  endfunction

  function automatic logic [SEG_W-1:0] rand_segment();
    logic [15:0] x0, y0;
    x0 = rand_coord();
    y0 = rand_coord();
    // Mostly short segments so that many pixels fall near a stroke.
    if ($urandom_range(3) == 0) return {rand_coord(), rand_coord(), y0, x0};
    return {y0 + 16'($urandom_range(512) - 256), x0 + 16'($urandom_range(512) - 256), y0, x0};
  endfunction

  // Extremes of pixel, segment and stroke-width values, zero-length segment, a count above the slots, empty set.
  task automatic test_directed();
    write_reg(CFG_IDX_SEG0, {16'd160, 16'd800, 16'd160, 16'd160});
    write_reg(CFG_IDX_SEG1, {16'd320, 16'd320, 16'd320, 16'd320});
    write_reg(CFG_IDX_SEG2, {16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
    write_reg(CFG_IDX_SEG3, {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF});
    write_reg(CFG_IDX_HALF, 64'd16);
    write_reg(CFG_IDX_NSEG, 64'd2);
    send_pixel(10, 10);
    send_pixel(20, 10);
    send_pixel(30, 10);
    send_pixel(11, 10);
    send_pixel(20, 20);
    send_pixel(21, 21);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    send_pixel(0, 1023);
    drain_results();
    write_reg(CFG_IDX_NSEG, 64'd4);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(512, 512);
    drain_results();
    write_reg(CFG_IDX_NSEG, 64'd7);
    send_pixel(10, 10);
    send_pixel(0, 1023);
    drain_results();
    write_reg(CFG_IDX_NSEG, 64'd0);
    send_pixel(10, 10);
    send_pixel(20, 20);
    drain_results();
    write_reg(CFG_IDX_HALF, 64'd4095);
    write_reg(CFG_IDX_NSEG, 64'd1);
    send_pixel(10, 10);
    send_pixel(200, 10);
    drain_results();
    write_reg(CFG_IDX_HALF, 64'd0);
    send_pixel(10, 10);
    send_pixel(10, 12);
    drain_results();
  endtask

  // Random segment sets and stroke widths, pixels near the strokes mostly.
  task automatic test_random(int phases, int per_phase);
    int s, cx, cy;
    for (int p = 0; p < phases; p++) begin
      for (int i = 0; i < CFG_SEGS; i++) begin
        write_reg(CFG_IDX_SEG0 + CFG_IDX_W'(i), rand_segment());
      end
      write_reg(CFG_IDX_NSEG, 64'($urandom_range(7)));
      case ($urandom_range(3))
        0: write_reg(CFG_IDX_HALF, 64'd0);
        1: write_reg(CFG_IDX_HALF, 64'd4095);
        default: write_reg(CFG_IDX_HALF, 64'($urandom_range(255)));
      endcase
      src_idle_en = (p % 4) != 1;
      sink_idle_en = (p % 4) != 1;
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(3) != 0) begin
          s = int'($urandom_range(3));
          cx = int'(coord16(shadow_seg[s], 0) >>> 4) + int'($urandom_range(40)) - 20;
          cy = int'(coord16(shadow_seg[s], 1) >>> 4) + int'($urandom_range(40)) - 20;
          send_pixel(10'(cx), 10'(cy));
        end else begin
          send_pixel(10'($urandom), 10'($urandom));
        end
      end
      drain_results();
    end
  endtask

  // Hold the sink off long enough that the pipeline fills and stalls input.
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    write_reg(CFG_IDX_NSEG, 64'd4);
    sink_hold_cycles <= 600;
    for (int k = 0; k < 200; k++) send_pixel(10'($urandom), 10'($urandom));
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < SEGMENT_SLOTS; i++) shadow_seg[i] = '0;
    shadow_nseg = 3'd4;
    shadow_half = 12'd16;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    test_directed();
    test_random(12, 60);
    test_backpressure();
    if (fail_count == 0 && pending_cov.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
src/psc_pkg.sv
src/psc_cell.sv
src/psc_isqrt.sv
src/polyline_stroke_coverage.sv
sim/polyline_stroke_coverage_tb.sv
